[rtl/i2c_temp_sensor_registers_core_defines.svh]
// Assertion macros shared by the temperature sensor register block.
// Included by the controller and datapath files; needs nothing else.
`ifndef I2C_TEMP_SENSOR_REGISTERS_CORE_DEFINES_SVH
`define I2C_TEMP_SENSOR_REGISTERS_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TSR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define TSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/i2ctsr_pkg.sv]
// Shared types and constants for the temperature sensor register block.
// No dependencies.
package i2ctsr_pkg;

  // Bus event codes.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Byte phase after a start condition.
  localparam logic [1:0] PH_POINTER = 2'd0;
  localparam logic [1:0] PH_FIRST   = 2'd1;
  localparam logic [1:0] PH_LATER   = 2'd2;

  // Register pointer codes.
  localparam logic [1:0] PTR_TEMP  = 2'd0;
  localparam logic [1:0] PTR_CONF  = 2'd1;
  localparam logic [1:0] PTR_HYST  = 2'd2;
  localparam logic [1:0] PTR_OTEMP = 2'd3;

  localparam int unsigned KEEP_PTR_BIT = 2;

  localparam logic [7:0] HYST_RST_HI  = 8'h4B;
  localparam logic [7:0] OTEMP_RST_HI = 8'h50;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } dp_cmd_t;

endpackage

[rtl/i2c_temp_sensor_registers_core.sv]
// Top level of the temperature sensor register block.
// Depends on i2ctsr_pkg, i2ctsr_ctrl and i2ctsr_dp.
//
//   Channel | Handshake                 | Payload
//   input   | start in, busy out        | in_op, in_data, in_temperature
//   result  | out_valid strobe (1 cycle) | out_read_data, out_ack
//
// Every event is first captured as a word and then executed.
// The result strobes in the cycle after execution, and busy is low again in
// that same cycle, so a new start can be taken while the result is shown.
// Reset (rst_n low at a clock edge) returns the phase, pointer and setpoints
// to their power-on values; no clearing pass is needed.
// The receiver cannot stall, so nothing ever holds a result back.
module i2c_temp_sensor_registers_core
  import i2ctsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_data,
  input  logic signed [7:0] in_temperature,
  output logic              out_valid,
  output logic [7:0]        out_read_data,
  output logic              out_ack
);

  dp_cmd_t cmd;

  i2ctsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  i2ctsr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_op          (in_op),
    .in_data        (in_data),
    .in_temperature (in_temperature),
    .out_read_data  (out_read_data),
    .out_ack        (out_ack)
  );

endmodule

[rtl/i2ctsr_ctrl.sv]
// Sequencer for the temperature sensor register block: capture, execute, strobe.
// Depends on i2ctsr_pkg and the shared assertion macros.
`include "i2c_temp_sensor_registers_core_defines.svh"

module i2ctsr_ctrl
  import i2ctsr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        valid_r, valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    busy        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = valid_r;

  `TSR_ASSERT_NEXT(a_exec_strobes, cmd.exec, out_valid, "executed word produced no strobe")
  `TSR_ASSERT_NOW(a_strobe_not_busy, out_valid, !busy, "strobe raised while busy")
  `TSR_ASSERT_NEXT(a_capture_execs, cmd.capture, cmd.exec, "captured word not executed")

endmodule

[rtl/i2ctsr_dp.sv]
// Datapath of the temperature sensor register block: event registers,
// phase, pointer, setpoint bytes and result registers.
// Depends on i2ctsr_pkg and the shared assertion macros.
`include "i2c_temp_sensor_registers_core_defines.svh"

module i2ctsr_dp
  import i2ctsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_data,
  input  logic signed [7:0] in_temperature,
  output logic [7:0]        out_read_data,
  output logic              out_ack
);

  // Captured event.
  logic [1:0] op_r;
  logic [7:0] data_r;
  logic [7:0] temp_r;

  logic [1:0] phase_r, phase_nxt;
  logic [1:0] ptr_r, ptr_nxt;
  logic [7:0] conf_r, conf_nxt;
  logic [7:0] hyst_hi_r, hyst_hi_nxt, hyst_lo_r, hyst_lo_nxt;
  logic [7:0] ot_hi_r, ot_hi_nxt, ot_lo_r, ot_lo_nxt;
  logic [7:0] rd_r, rd_nxt;
  logic       ack_r, ack_nxt;

  logic [1:0] rd_phase;
  logic       first;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      data_r <= in_data;
      temp_r <= in_temperature;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_POINTER;
      ptr_r     <= PTR_TEMP;
      conf_r    <= 8'h00;
      hyst_hi_r <= HYST_RST_HI;
      hyst_lo_r <= 8'h00;
      ot_hi_r   <= OTEMP_RST_HI;
      ot_lo_r   <= 8'h00;
    end else if (cmd.exec) begin
      phase_r   <= phase_nxt;
      ptr_r     <= ptr_nxt;
      conf_r    <= conf_nxt;
      hyst_hi_r <= hyst_hi_nxt;
      hyst_lo_r <= hyst_lo_nxt;
      ot_hi_r   <= ot_hi_nxt;
      ot_lo_r   <= ot_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_r  <= rd_nxt;
      ack_r <= ack_nxt;
    end
  end

  // A read right after a start counts as the first data byte.
  assign rd_phase = (phase_r == PH_POINTER) ? PH_FIRST : phase_r;

  always_comb begin
    phase_nxt   = phase_r;
    ptr_nxt     = ptr_r;
    conf_nxt    = conf_r;
    hyst_hi_nxt = hyst_hi_r;
    hyst_lo_nxt = hyst_lo_r;
    ot_hi_nxt   = ot_hi_r;
    ot_lo_nxt   = ot_lo_r;
    rd_nxt      = 8'h00;
    ack_nxt     = 1'b1;
    first       = 1'b0;
    unique case (op_r)
      OP_START: phase_nxt = PH_POINTER;
      OP_READ: begin
        first = (rd_phase == PH_FIRST);
        unique case (ptr_r)
          PTR_TEMP:  rd_nxt = first ? temp_r : 8'h00;
          PTR_CONF:  rd_nxt = conf_r;
          PTR_HYST:  rd_nxt = first ? hyst_hi_r : hyst_lo_r;
          PTR_OTEMP: rd_nxt = first ? ot_hi_r : ot_lo_r;
          default:   rd_nxt = 8'h00;
        endcase
        if (first) begin
          phase_nxt = PH_LATER;
        end else begin
          phase_nxt = rd_phase;
        end
      end
      OP_WRITE: begin
        first = (phase_r == PH_FIRST);
        priority if (phase_r == PH_POINTER) begin
          phase_nxt = PH_FIRST;
          if (!data_r[KEEP_PTR_BIT]) begin
            ptr_nxt = data_r[1:0];
          end
        end else if (first || (phase_r == PH_LATER && ptr_r != PTR_CONF)) begin
          unique case (ptr_r)
            PTR_TEMP:  ;
            PTR_CONF:  conf_nxt = data_r;
            PTR_HYST:  begin
              if (first) begin
                hyst_hi_nxt = data_r;
              end else begin
                hyst_lo_nxt = data_r;
              end
            end
            PTR_OTEMP: begin
              if (first) begin
                ot_hi_nxt = data_r;
              end else begin
                ot_lo_nxt = data_r;
              end
            end
            default: ;
          endcase
          if (first) begin
            phase_nxt = PH_LATER;
          end
        end else begin
          // Second configuration byte, or a phase that cannot arise.
          ack_nxt = 1'b0;
        end
      end
      default: ack_nxt = 1'b0;
    endcase
  end

  assign out_read_data = rd_r;
  assign out_ack       = ack_r;

  `TSR_ASSERT_NOW(a_phase_legal, 1'b1, phase_r != 2'd3, "byte phase reached an unused value")
  `TSR_ASSERT_NEXT(a_read_acked, cmd.exec && op_r == OP_READ, out_ack, "read word not acked")
  `TSR_ASSERT_NEXT(a_conf_refused,
    cmd.exec && op_r == OP_WRITE && phase_r == PH_LATER && ptr_r == PTR_CONF,
    $stable(conf_r) && !out_ack, "second configuration word was taken")

endmodule

[verif/i2c_temp_sensor_registers_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the temperature sensor register block: predicts each reply word.
// Depends on i2ctsr_pkg; instantiated next to the block by the testbench top.
module i2c_temp_sensor_registers_checker
  import i2ctsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_op,
  input  logic [7:0]        in_data,
  input  logic signed [7:0] in_temperature,
  input  logic              out_valid,
  input  logic [7:0]        out_read_data,
  input  logic              out_ack,
  output int                fail_count,
  output int                pending_cnt
);

  typedef struct packed {
    logic [7:0] read_data;
    logic       ack;
  } bus_reply_t;

  // Shadow copy of the sensor registers.
  logic [1:0] phase_q;
  logic [1:0] pointer_q;
  logic [7:0] conf_q;
  logic [7:0] hyst_q [2];
  logic [7:0] otemp_q [2];

  bus_reply_t reply_q [$];
  int         errors = 0;

  function automatic void reset_sensor_regs();
    phase_q    = PH_POINTER;
    pointer_q  = PTR_TEMP;
    conf_q     = 8'h00;
    hyst_q[0]  = HYST_RST_HI;
    hyst_q[1]  = 8'h00;
    otemp_q[0] = OTEMP_RST_HI;
    otemp_q[1] = 8'h00;
  endfunction

  function automatic bus_reply_t apply_bus_event(logic [1:0] op, logic [7:0] data,
                                                 logic [7:0] temp);
    bus_reply_t reply;
    logic       first;
    reply.read_data = 8'h00;
    reply.ack       = 1'b1;
    case (op)
      OP_START: begin
        phase_q = PH_POINTER;
      end
      OP_READ: begin
        // A read right after a start counts as the first data byte.
        if (phase_q == PH_POINTER) phase_q = PH_FIRST;
        first = (phase_q == PH_FIRST);
        case (pointer_q)
          PTR_TEMP: reply.read_data = first ? temp : 8'h00;
          PTR_CONF: reply.read_data = conf_q;
          PTR_HYST: reply.read_data = first ? hyst_q[0] : hyst_q[1];
          default:  reply.read_data = first ? otemp_q[0] : otemp_q[1];
        endcase
        if (phase_q < PH_LATER) phase_q = phase_q + 2'd1;
      end
      OP_WRITE: begin
        first = (phase_q == PH_FIRST);
        if (phase_q > PH_LATER || (phase_q == PH_LATER && pointer_q == PTR_CONF)) begin
          reply.ack = 1'b0;
        end else if (phase_q == PH_POINTER) begin
          phase_q = PH_FIRST;
          if (!data[KEEP_PTR_BIT]) pointer_q = data[1:0];
        end else begin
          case (pointer_q)
            PTR_TEMP: ;
            PTR_CONF: conf_q = data;
            PTR_HYST: hyst_q[first ? 0 : 1] = data;
            default:  otemp_q[first ? 0 : 1] = data;
          endcase
          if (phase_q == PH_FIRST) phase_q = PH_LATER;
        end
      end
      default: begin
        reply.ack = 1'b0;
      end
    endcase
    return reply;
  endfunction

  always @(posedge clk) begin
    bus_reply_t want;
    if (!rst_n) begin
      reset_sensor_regs();
      reply_q.delete();
    end else begin
      // A reply shown in this cycle belongs to an earlier word, so check first.
      if (out_valid) begin
        if (reply_q.size() == 0) begin
          $error("reply word with no expectation: read_data %0h ack %0b",
                 out_read_data, out_ack);
          errors++;
        end else begin
          want = reply_q.pop_front();
          if (out_read_data !== want.read_data) begin
            $error("read_data mismatch: expected %0h, got %0h", want.read_data, out_read_data);
            errors++;
          end
          if (out_ack !== want.ack) begin
            $error("ack mismatch: expected %0b, got %0b", want.ack, out_ack);
            errors++;
          end
        end
      end
      if (start && !busy)
        reply_q.push_back(apply_bus_event(in_op, in_data, in_temperature));
    end
    fail_count  <= errors;
    pending_cnt <= reply_q.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for the temperature sensor register block.
// Depends on i2ctsr_pkg, the block's RTL and i2c_temp_sensor_registers_checker.
module testbench
  import i2ctsr_pkg::*;
;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_op;
  logic [7:0]        in_data;
  logic signed [7:0] in_temperature;
  logic              out_valid;
  logic [7:0]        out_read_data;
  logic              out_ack;
  int                fail_count;
  int                pending_cnt;

  int words_sent;
  int sender_idle_pct;

  i2c_temp_sensor_registers_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_data       (in_data),
    .in_temperature(in_temperature),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_ack       (out_ack)
  );

  i2c_temp_sensor_registers_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_data       (in_data),
    .in_temperature(in_temperature),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_ack       (out_ack),
    .fail_count    (fail_count),
    .pending_cnt   (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [7:0] pick_temperature();
    case ($urandom_range(7))
      0:       return 8'h80;
      1:       return 8'h7F;
      2:       return $urandom_range(1) ? 8'h00 : 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Presents one word and returns once the block has taken it.
  task automatic send_word(logic [1:0] op, logic [7:0] data, logic [7:0] temp);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_op          <= op;
    in_data        <= data;
    in_temperature <= temp;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  // A start, usually a pointer byte, then a few data reads and writes.
  task automatic send_transfer();
    logic [7:0] ptr_byte;
    int         n_bytes;
    send_word(OP_START, 8'($urandom), pick_temperature());
    if ($urandom_range(3) != 0) begin
      ptr_byte = 8'($urandom);
      if ($urandom_range(4) != 0) ptr_byte[KEEP_PTR_BIT] = 1'b0;
      send_word(OP_WRITE, ptr_byte, pick_temperature());
    end
    n_bytes = $urandom_range(1, 4);
    repeat (n_bytes)
      send_word($urandom_range(1) ? OP_READ : OP_WRITE, 8'($urandom), pick_temperature());
  endtask

  task automatic send_noise();
    logic [1:0] op;
    op = ($urandom_range(49) == 0) ? 2'd3 : 2'($urandom_range(2));
    send_word(op, 8'($urandom), pick_temperature());
  endtask

  initial begin
    int phase_pct [4];
    int target;
    int waited;
    phase_pct  = '{0, 88, 0, 21};
    words_sent = 0;
    sender_idle_pct = 0;
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_op          <= OP_START;
    in_data        <= 8'h00;
    in_temperature <= 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A read straight out of reset counts as the first data byte.
    send_word(OP_READ,  8'hFF, 8'h80);
    send_word(OP_READ,  8'h00, 8'h7F);
    // Hysteresis reset value, low byte repeating.
    send_word(OP_START, 8'h00, 8'h00);
    send_word(OP_WRITE, 8'h02, 8'h00);
    send_word(OP_READ,  8'h00, 8'h00);
    send_word(OP_READ,  8'h00, 8'h00);
    send_word(OP_READ,  8'h00, 8'h00);
    // Overtemperature limit written, then read back with the pointer kept.
    send_word(OP_START, 8'h00, 8'h00);
    send_word(OP_WRITE, 8'h03, 8'h00);
    send_word(OP_WRITE, 8'hFF, 8'h00);
    send_word(OP_WRITE, 8'h00, 8'h00);
    send_word(OP_START, 8'h00, 8'h00);
    send_word(OP_READ,  8'h00, 8'h00);
    send_word(OP_READ,  8'h00, 8'h00);
    // Configuration: the second byte must be refused.
    send_word(OP_START, 8'h00, 8'h00);
    send_word(OP_WRITE, 8'h01, 8'h00);
    send_word(OP_WRITE, 8'hA5, 8'h00);
    send_word(OP_WRITE, 8'h5A, 8'h00);
    // Pointer byte with the keep bit set leaves the configuration selected.
    send_word(OP_START, 8'h00, 8'h00);
    send_word(OP_WRITE, 8'hFE, 8'h00);
    send_word(OP_READ,  8'h00, 8'h00);
    // Temperature write is acknowledged but dropped.
    send_word(OP_START, 8'h00, 8'h00);
    send_word(OP_WRITE, 8'h00, 8'h00);
    send_word(OP_WRITE, 8'h77, 8'h80);
    send_word(OP_READ,  8'h00, 8'h80);
    // Unused event code is not acknowledged and changes nothing.
    send_word(2'd3,     8'hFF, 8'h7F);

    target = words_sent;
    foreach (phase_pct[i]) begin
      // The sender holds off until every reply of the last phase is back.
      drain_replies();
      sender_idle_pct = phase_pct[i];
      target += 285;
      while (words_sent < target) begin
        if ($urandom_range(99) < 85) send_transfer();
        else send_noise();
      end
    end

    start  <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (pending_cnt != 0 && waited < 100) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/i2ctsr_pkg.sv
rtl/i2ctsr_ctrl.sv
rtl/i2ctsr_dp.sv
rtl/i2c_temp_sensor_registers_core.sv
verif/i2c_temp_sensor_registers_checker.sv
verif/testbench.sv
